[rtl/pdrq_pkg.sv]
// ----------------------------------------------------------------------------
// pdrq_pkg
// Shared widths, link codes and bundle types for the pickup request queue.
// ----------------------------------------------------------------------------
package pdrq_pkg;

	localparam int TRACK_W = 10;
	localparam int TAG_W   = 16;
	localparam int COUNT_W = 6;

	// search state handed from one cell to the next
	localparam logic [1:0] ST_SEARCH = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_PLACE  = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	typedef struct packed {
		logic [1:0] st;
		logic       after;   // insert position lies left of this cell
	} link_t;

	typedef struct packed {
		logic               ins;
		logic               pop;
		logic [TRACK_W-1:0] track;
		logic [TAG_W-1:0]   tag;
	} op_t;

endpackage

[rtl/pdrq_cell.sv]
// ----------------------------------------------------------------------------
// pdrq_cell
// One queue slot: holds a track and tag, finds the insert point with its
// neighbours and shifts on insert or pop.
// ----------------------------------------------------------------------------
module pdrq_cell (
	input  logic                          clk,
	input  pdrq_pkg::op_t                 op,
	input  pdrq_pkg::link_t               link_i,
	input  logic                          vld,
	input  logic                          vld_next,
	input  logic [pdrq_pkg::TRACK_W-1:0]  left_track,
	input  logic [pdrq_pkg::TAG_W-1:0]    left_tag,
	input  logic [pdrq_pkg::TRACK_W-1:0]  right_track,
	input  logic [pdrq_pkg::TAG_W-1:0]    right_tag,
	output pdrq_pkg::link_t               link_o,
	output logic [pdrq_pkg::TRACK_W-1:0]  track_o,
	output logic [pdrq_pkg::TAG_W-1:0]    tag_o,
	output logic [pdrq_pkg::TRACK_W-1:0]  track_d,
	output logic [pdrq_pkg::TAG_W-1:0]    tag_d
);
	import pdrq_pkg::*;

	logic [TRACK_W-1:0] track_q;
	logic [TAG_W-1:0]   tag_q;
	logic               same;
	logic               between;
	logic               here;

	assign same    = (track_q == op.track);
	assign between = ((track_q > op.track) && (right_track < op.track)) ||
	                 ((track_q < op.track) && (right_track > op.track));

	always_comb begin
		here      = 1'b0;
		link_o.st = ST_DONE;
		unique case (link_i.st)
			ST_DONE: begin
				link_o.st = ST_DONE;
			end
			ST_PLACE: begin
				here      = 1'b1;
				link_o.st = ST_DONE;
			end
			ST_RUN: begin
				// end of a run of equal tracks
				if (vld && same) begin
					link_o.st = ST_RUN;
				end else begin
					here      = 1'b1;
					link_o.st = ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (!vld) begin
					here      = 1'b1;
					link_o.st = ST_DONE;
				end else if (vld_next && same) begin
					link_o.st = ST_RUN;
				end else if (vld_next && between) begin
					link_o.st = ST_PLACE;
				end else begin
					link_o.st = ST_SEARCH;
				end
			end
			default: begin
				link_o.st = ST_DONE;
			end
		endcase
		link_o.after = link_i.after | here;
	end

	always_comb begin
		track_d = track_q;
		tag_d   = tag_q;
		if (op.ins) begin
			if (link_i.after) begin
				track_d = left_track;
				tag_d   = left_tag;
			end else if (here) begin
				track_d = op.track;
				tag_d   = op.tag;
			end
		end else if (op.pop) begin
			track_d = right_track;
			tag_d   = right_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (op.ins || op.pop) begin
			track_q <= track_d;
			tag_q   <= tag_d;
		end
	end

	assign track_o = track_q;
	assign tag_o   = tag_q;

endmodule

[rtl/pickup_disk_request_queue_core.sv]
// ----------------------------------------------------------------------------
// pickup_disk_request_queue_core
// Ordered disk request queue with pickup insertion, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a clock edge with start high and busy low.
//   kind 0 inserts (req_track, req_tag), kind 1 removes the head request.
//   Each command gives one result beat, marked by done, in the cycle after
//   the command: head_valid, head_track, head_tag, entry_count and dropped.
//   A new command can be given every cycle while busy is low: every
//   cell compares the new track with its own and its right neighbour's entry
//   and the search state ripples along the row in the same cycle.
//   An insert into a full queue leaves the queue alone and raises dropped.
//   A pop of an empty queue changes nothing.
//   Tracks at or above TRACK_COUNT are clamped to TRACK_COUNT-1.
//   Reset empties the queue; busy is high during reset and stays high
//   until the next clock edge after its release. The result side cannot stall:
//   a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module pickup_disk_request_queue_core #(
	parameter int QUEUE_DEPTH = 32,
	parameter int TRACK_COUNT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [pdrq_pkg::TRACK_W-1:0]  req_track,
	input  logic [pdrq_pkg::TAG_W-1:0]    req_tag,
	output logic                          done,
	output logic                          head_valid,
	output logic [pdrq_pkg::TRACK_W-1:0]  head_track,
	output logic [pdrq_pkg::TAG_W-1:0]    head_tag,
	output logic [pdrq_pkg::COUNT_W-1:0]  entry_count,
	output logic                          dropped
);
	import pdrq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned TrackMax = TRACK_COUNT - 1;

	logic               ready_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               accept;
	logic               full;
	logic [TRACK_W-1:0] track_sat;
	op_t                op;

	link_t              link  [QUEUE_DEPTH+1];
	logic [TRACK_W-1:0] trk   [QUEUE_DEPTH];
	logic [TAG_W-1:0]   tg    [QUEUE_DEPTH];
	logic [TRACK_W-1:0] trk_d [QUEUE_DEPTH];
	logic [TAG_W-1:0]   tg_d  [QUEUE_DEPTH];

	logic               done_q;
	logic               head_valid_q;
	logic [TRACK_W-1:0] head_track_q;
	logic [TAG_W-1:0]   head_tag_q;
	logic [CNT_W-1:0]   entry_count_q;
	logic               dropped_q;

	assign busy   = ~ready_q;
	assign accept = start & ready_q;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		if (32'(req_track) > TrackMax) begin
			track_sat = TRACK_W'(TrackMax);
		end else begin
			track_sat = req_track;
		end
	end

	assign op.ins   = accept & ~kind & ~full;
	assign op.pop   = accept & kind & (count_q != '0);
	assign op.track = track_sat;
	assign op.tag   = req_tag;

	always_comb begin
		count_d = count_q;
		if (op.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (op.pop) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign link[0].st    = ST_SEARCH;
	assign link[0].after = 1'b0;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic [TRACK_W-1:0] left_track;
		logic [TAG_W-1:0]   left_tag;
		logic [TRACK_W-1:0] right_track;
		logic [TAG_W-1:0]   right_tag;
		logic               vld;
		logic               vld_next;

		if (k == 0) begin : g_first
			assign left_track = op.track;
			assign left_tag   = op.tag;
		end else begin : g_mid
			assign left_track = trk[k-1];
			assign left_tag   = tg[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_last
			assign right_track = '0;
			assign right_tag   = '0;
		end else begin : g_inner
			assign right_track = trk[k+1];
			assign right_tag   = tg[k+1];
		end

		assign vld      = (CNT_W'(k) < count_q);
		assign vld_next = (CNT_W'(k + 1) < count_q);

		pdrq_cell u_cell (
			.clk         (clk),
			.op          (op),
			.link_i      (link[k]),
			.vld         (vld),
			.vld_next    (vld_next),
			.left_track  (left_track),
			.left_tag    (left_tag),
			.right_track (right_track),
			.right_tag   (right_tag),
			.link_o      (link[k+1]),
			.track_o     (trk[k]),
			.tag_o       (tg[k]),
			.track_d     (trk_d[k]),
			.tag_d       (tg_d[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q      <= 1'b0;
			count_q      <= '0;
			done_q       <= 1'b0;
			head_valid_q <= 1'b0;
			dropped_q    <= 1'b0;
		end else begin
			ready_q      <= 1'b1;
			count_q      <= count_d;
			done_q       <= accept;
			head_valid_q <= (count_d != '0);
			dropped_q    <= accept & ~kind & full;
		end
	end

	// result payload, zero when the queue ends up empty
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_count_q <= count_d;
			if (count_d != '0) begin
				head_track_q <= trk_d[0];
				head_tag_q   <= tg_d[0];
			end else begin
				head_track_q <= '0;
				head_tag_q   <= '0;
			end
		end
	end

	assign done        = done_q;
	assign head_valid  = head_valid_q;
	assign head_track  = head_track_q;
	assign head_tag    = head_tag_q;
	assign entry_count = COUNT_W'(entry_count_q);
	assign dropped     = dropped_q;

	// link[QUEUE_DEPTH] marks an insert past the last cell, which cannot
	// happen since a full queue drops the insert
	logic unused_tail;
	assign unused_tail = ^{link[QUEUE_DEPTH].st, link[QUEUE_DEPTH].after};

endmodule

[rtl/pdrq_checker.sv]
// ----------------------------------------------------------------------------
// pdrq_checker
// Port-level checks on the pickup request queue, bound to the top level.
// ----------------------------------------------------------------------------
module pdrq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          kind,
	input logic [pdrq_pkg::TRACK_W-1:0]  req_track,
	input logic [pdrq_pkg::TAG_W-1:0]    req_tag,
	input logic                          done,
	input logic                          head_valid,
	input logic [pdrq_pkg::TRACK_W-1:0]  head_track,
	input logic [pdrq_pkg::TAG_W-1:0]    head_tag,
	input logic [pdrq_pkg::COUNT_W-1:0]  entry_count,
	input logic                          dropped
);
	import pdrq_pkg::*;

	logic cmd_beat;
	assign cmd_beat = start && !busy;

	// every command beat gives exactly one result beat in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_beat |=> done)
		else $error("command beat without result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_beat |=> !done)
		else $error("result beat without command beat");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !head_valid |-> head_track == '0 && head_tag == '0 &&
			entry_count == '0)
		else $error("empty queue reports non-zero head or count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && dropped |-> head_valid && $past(!kind))
		else $error("drop reported on a pop or an empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && $past(kind) && !dropped |->
			entry_count == $past(entry_count) - COUNT_W'(1) ||
			entry_count == '0)
		else $error("pop did not shrink the queue by one");

	// keep every port in use for lint
	logic unused_in;
	assign unused_in = ^{req_track, req_tag};

endmodule

bind pickup_disk_request_queue_core pdrq_checker u_pdrq_checker (.*);

[test/pickup_disk_request_queue_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pickup_disk_request_queue_core_tb
// Self-checking bench for the pickup request queue. Insert and pop commands go
// in through the start/busy handshake; a queue model in the bench works out
// the head, the count and the drop flag for each command and compares them
// field by field with every result beat that done marks.
// ----------------------------------------------------------------------------
module pickup_disk_request_queue_core_tb;

	import pdrq_pkg::*;

	localparam int QUEUE_DEPTH  = 32;
	localparam int TRACK_COUNT  = 1024;
	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_LIMIT  = 500;
	localparam int DRAIN_CYCLES = 4;

	localparam bit OP_INSERT = 1'b0;
	localparam bit OP_POP    = 1'b1;

	typedef struct packed {
		logic               head_valid;
		logic [TRACK_W-1:0] head_track;
		logic [TAG_W-1:0]   head_tag;
		logic [COUNT_W-1:0] entry_count;
		logic               dropped;
	} head_report_t;

	class pickup_queue_board;
		logic [TRACK_W-1:0] slot_trk [QUEUE_DEPTH];
		logic [TAG_W-1:0]   slot_tg  [QUEUE_DEPTH];
		int unsigned        fill;
		head_report_t       pending_heads [$];
		int unsigned        mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		// first pair the new track sits strictly between, or after a run of equal tracks
		function int unsigned pickup_slot(logic [TRACK_W-1:0] t);
			int unsigned j;
			for (int unsigned i = 0; i + 1 < fill; i++) begin
				if (slot_trk[i] == t) begin
					j = i + 1;
					while (j < fill && slot_trk[j] == t)
						j++;
					return j;
				end
				if ((slot_trk[i] > t && slot_trk[i+1] < t) ||
				    (slot_trk[i] < t && slot_trk[i+1] > t))
					return i + 1;
			end
			return fill;
		endfunction

		function void take_command(bit op, logic [TRACK_W-1:0] trk, logic [TAG_W-1:0] tg);
			head_report_t rep;
			int unsigned  pos;
			rep = '0;
			if (trk >= TRACK_COUNT)
				trk = TRACK_W'(TRACK_COUNT - 1);
			if (op == OP_INSERT) begin
				if (fill >= QUEUE_DEPTH) begin
					rep.dropped = 1'b1;
				end else begin
					pos = pickup_slot(trk);
					for (int unsigned k = fill; k > pos; k--) begin
						slot_trk[k] = slot_trk[k-1];
						slot_tg[k]  = slot_tg[k-1];
					end
					slot_trk[pos] = trk;
					slot_tg[pos]  = tg;
					fill++;
				end
			end else if (fill > 0) begin
				for (int unsigned k = 0; k + 1 < fill; k++) begin
					slot_trk[k] = slot_trk[k+1];
					slot_tg[k]  = slot_tg[k+1];
				end
				fill--;
			end
			if (fill > 0) begin
				rep.head_valid = 1'b1;
				rep.head_track = slot_trk[0];
				rep.head_tag   = slot_tg[0];
			end
			rep.entry_count = fill[COUNT_W-1:0];
			pending_heads.push_back(rep);
		endfunction

		function void match_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_head(head_report_t got);
			head_report_t want;
			if (pending_heads.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing expected, expected none, actual %p",
					$time, got);
				return;
			end
			want = pending_heads.pop_front();
			match_field("head_valid", TAG_W'(want.head_valid), TAG_W'(got.head_valid));
			match_field("head_track", TAG_W'(want.head_track), TAG_W'(got.head_track));
			match_field("head_tag", want.head_tag, got.head_tag);
			match_field("entry_count", TAG_W'(want.entry_count), TAG_W'(got.entry_count));
			match_field("dropped", TAG_W'(want.dropped), TAG_W'(got.dropped));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               kind;
	logic [TRACK_W-1:0] req_track;
	logic [TAG_W-1:0]   req_tag;
	logic               done;
	logic               head_valid;
	logic [TRACK_W-1:0] head_track;
	logic [TAG_W-1:0]   head_tag;
	logic [COUNT_W-1:0] entry_count;
	logic               dropped;

	pickup_queue_board board;
	int unsigned       quiet_cycles;

	pickup_disk_request_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TRACK_COUNT(TRACK_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.req_track(req_track),
		.req_tag(req_tag),
		.done(done),
		.head_valid(head_valid),
		.head_track(head_track),
		.head_tag(head_tag),
		.entry_count(entry_count),
		.dropped(dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// command beats are noted before result beats, so a same-edge result still finds its entry
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.take_command(kind, req_track, req_tag);
		if (arst_n && done)
			board.check_head({head_valid, head_track, head_tag, entry_count, dropped});
		if ((arst_n && start && !busy) || (arst_n && done))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		@(posedge clk);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("** pickup_disk_request_queue_core: FAILED **");
		$finish;
	end

	task automatic send_command(input bit op, input logic [TRACK_W-1:0] trk,
			input logic [TAG_W-1:0] tg, input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		kind      <= op;
		req_track <= trk;
		req_tag   <= tg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [TRACK_W-1:0] pick_track();
		case ($urandom_range(0, 3))
			0: return TRACK_W'($urandom_range(0, TRACK_COUNT - 1));
			1: return $urandom_range(0, 1) ? TRACK_W'(TRACK_COUNT - 1) : '0;
			// coarse grid so equal tracks and runs turn up often
			2: return TRACK_W'($urandom_range(0, 5) * 200);
			default: return TRACK_W'(500 + $urandom_range(0, 6) - 3);
		endcase
	endfunction

	initial begin
		int unsigned issued;
		int unsigned seg_len;
		int unsigned ins_pct;
		bit          no_idle;
		bit          op;

		board     = new();
		arst_n    <= 1'b0;
		start     <= 1'b0;
		kind      <= OP_INSERT;
		req_track <= '0;
		req_tag   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// pop of an empty queue, then first entry and the extremes
		send_command(OP_POP, 10'h3ff, 16'hffff, 0);
		send_command(OP_INSERT, 10'd0, 16'h0000, 0);
		send_command(OP_INSERT, 10'd1023, 16'hffff, 1);
		send_command(OP_INSERT, 10'd500, 16'h1234, 0);
		send_command(OP_INSERT, 10'd500, 16'h1235, 0);
		// equal track only at the tail gets appended
		send_command(OP_INSERT, 10'd1023, 16'hbeef, 2);
		send_command(OP_INSERT, 10'd0, 16'h0001, 0);
		repeat (8)
			send_command(OP_POP, 10'd0, 16'h0000, $urandom_range(0, 1));
		// descending neighbours: 500 lands between 900 and 100
		send_command(OP_INSERT, 10'd900, 16'haaaa, 0);
		send_command(OP_INSERT, 10'd100, 16'h5555, 0);
		send_command(OP_INSERT, 10'd500, 16'h0f0f, 0);
		send_command(OP_INSERT, 10'd900, 16'hf0f0, 3);
		send_command(OP_INSERT, 10'd100, 16'h00ff, 0);
		repeat (5)
			send_command(OP_POP, 10'h155, 16'h5a5a, 0);

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			seg_len = $urandom_range(10, 80);
			case ($urandom_range(0, 3))
				0: ins_pct = 25;
				1: ins_pct = 50;
				2: ins_pct = 75;
				default: ins_pct = 97;
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (seg_len) begin
				op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP;
				send_command(op, pick_track(), TAG_W'($urandom),
					no_idle ? 0 : $urandom_range(0, 5));
				issued++;
			end
		end
		start <= 1'b0;

		while (board.pending_heads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("** pickup_disk_request_queue_core: PASSED **");
		else
			$display("** pickup_disk_request_queue_core: FAILED **");
		$finish;
	end

endmodule
